>>> rtl/gvbm_pkg.sv
// ----------------------------------------------------------------------------
// gvbm_pkg: shared definitions of the greedy voxel box merger
// Commands, result kinds, register indexes and default sizes.
// ----------------------------------------------------------------------------
package gvbm_pkg;

  // Default store dimensions.
  localparam int MAX_SIDE_DEF   = 16;
  localparam int MAX_HEIGHT_DEF = 16;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GRID_SIDE      = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_MERGE_MODE     = 2'd2,
    REG_LAYER_MATERIAL = 2'd3
  } reg_idx_t;

  // Register reset values.
  localparam logic [4:0] GRID_SIDE_RST      = 5'd16;
  localparam logic [4:0] GRID_HEIGHT_RST    = 5'd16;
  localparam logic       MERGE_MODE_RST     = 1'b0;
  localparam logic [7:0] LAYER_MATERIAL_RST = 8'd1;

endpackage

>>> rtl/gvbm_ram.sv
// ----------------------------------------------------------------------------
// gvbm_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module gvbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/greedy_voxel_box_merger.sv
// ----------------------------------------------------------------------------
// greedy_voxel_box_merger: greedy box merging over a voxel store
// Voxels are written one by one; each fetch returns a merged box, a single
// leftover voxel of the configured material, or a done item.
// ----------------------------------------------------------------------------
//   channel   ports                            handshake
//   input     in_command, in_pos_*, in_cell    in_valid / in_ready
//   result    out_item_kind, out_[xyz]_*       out_valid / out_ready
//   config    psel penable pwrite paddr ...    APB write, pready always high
//
// Write and start items are done in the idle state. In a fetch every cell probe
// goes through the single read port of the voxel RAM, and a level is rescanned
// for each box found.
// After reset a clearing pass writes zero to all MAX_HEIGHT*MAX_SIDE*MAX_SIDE
// cells before the first item is taken.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a fetch waits at its end only for that register to free.
// ----------------------------------------------------------------------------
module greedy_voxel_box_merger #(
  parameter int MAX_SIDE   = gvbm_pkg::MAX_SIDE_DEF,
  parameter int MAX_HEIGHT = gvbm_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_pos_x,
  input  logic [3:0]  in_pos_y,
  input  logic [3:0]  in_pos_z,
  input  logic [7:0]  in_cell_value,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [3:0]  out_x_low,
  output logic [3:0]  out_x_high,
  output logic [3:0]  out_y_low,
  output logic [3:0]  out_y_high,
  output logic [3:0]  out_z_low,
  output logic [3:0]  out_z_high,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import gvbm_pkg::*;

  localparam int DEPTH = MAX_HEIGHT * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_SIDE + 1);
  localparam int ZW    = $clog2(MAX_HEIGHT + 1);
  localparam int SSW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int PW    = 2 * CW;
  localparam int NW    = 2 * CW + ZW;

  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [ZW-1:0] ONE_Z = ZW'(1);

  // Growth directions, used as indexes into the stop flags.
  localparam logic [1:0] DIR_X = 2'd0;
  localparam logic [1:0] DIR_Y = 2'd1;
  localparam logic [1:0] DIR_Z = 2'd2;

  typedef enum logic [20:0] {
    S_CLEAR = 21'h000001,
    S_IDLE  = 21'h000002,
    S_MUL1  = 21'h000004,
    S_MUL2  = 21'h000008,
    S_LVL   = 21'h000010,
    S_SEED  = 21'h000020,
    S_NB1   = 21'h000040,
    S_NB2   = 21'h000080,
    S_NB3   = 21'h000100,
    S_ADV   = 21'h000200,
    S_GDIR  = 21'h000400,
    S_SLAB  = 21'h000800,
    S_EV1   = 21'h001000,
    S_EV2   = 21'h002000,
    S_LEND  = 21'h004000,
    S_BCLR  = 21'h008000,
    S_SCHK  = 21'h010000,
    S_DIVZ  = 21'h020000,
    S_DIVX  = 21'h040000,
    S_SCAN  = 21'h080000,
    S_EMIT  = 21'h100000
  } state_t;

  typedef enum logic [1:0] {
    PH_MERGE  = 2'd0,
    PH_SINGLE = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  state_t        state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [4:0] grid_side_r, grid_height_r;
  logic       merge_mode_r;
  logic [7:0] layer_mat_r;

  logic [ZW-1:0]  lvl_r, lvl_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [SSW-1:0] ss_r, ss_nxt;
  logic [IW-1:0]  total_r, total_nxt;
  logic [IW-1:0]  rem_r, rem_nxt;

  logic [CW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CW-1:0] x2_r, x2_nxt, y2_r, y2_nxt;
  logic [ZW-1:0] z2_r, z2_nxt;
  logic [2:0]    fl_r, fl_nxt;
  logic [1:0]    dir_r, dir_nxt;

  logic [CW-1:0] lox_r, lox_nxt, hix_r, hix_nxt, loy_r, loy_nxt, hiy_r, hiy_nxt;
  logic [ZW-1:0] loz_r, loz_nxt, hiz_r, hiz_nxt;
  logic [ZW-1:0] pz_r, pz_nxt;
  logic [CW-1:0] px_r, px_nxt, py_r, py_nxt;

  logic [PW-1:0] prod_r, prod_nxt;
  logic [NW-1:0] best_r, best_nxt;
  logic [CW-1:0] bx1_r, bx1_nxt, bx2_r, bx2_nxt, by1_r, by1_nxt, by2_r, by2_nxt;
  logic [ZW-1:0] bz2_r, bz2_nxt;

  logic [1:0] res_kind_r, res_kind_nxt;
  logic [3:0] res_x1_r, res_x1_nxt, res_x2_r, res_x2_nxt;
  logic [3:0] res_y1_r, res_y1_nxt, res_y2_r, res_y2_nxt;
  logic [3:0] res_z1_r, res_z1_nxt, res_z2_r, res_z2_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r;
  logic [3:0] out_x1_r, out_x2_r, out_y1_r, out_y2_r, out_z1_r, out_z2_r;
  logic       out_load;

  logic [CW-1:0] side_s;
  logic [ZW-1:0] height_s;
  logic          cell_mat;
  logic          p_last;
  logic [CW-1:0] dx;
  logic [ZW-1:0] dz;
  logic [NW-1:0] n_cells;
  logic          cfg_we;
  logic          in_acc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Linear store address of a cell, y fastest.
  function automatic logic [AW-1:0] cell_addr(input logic [ZW-1:0] z,
                                               input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
    return AW'(int'(z) * (MAX_SIDE * MAX_SIDE) + int'(x) * MAX_SIDE + int'(y));
  endfunction

  function automatic logic [1:0] next_dir(input logic [1:0] d);
    logic [1:0] r;
    case (d)
      DIR_X:   r = DIR_Y;
      DIR_Y:   r = DIR_Z;
      default: r = DIR_X;
    endcase
    return r;
  endfunction

  // Configured grid clamped to the store size.
  always_comb begin
    side_s   = (int'(grid_side_r) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(grid_side_r);
    height_s = (int'(grid_height_r) > MAX_HEIGHT) ? ZW'(MAX_HEIGHT) : ZW'(grid_height_r);
  end

  // The read data always belongs to the current probe coordinates.
  assign cell_mat = (px_r < side_s) && (py_r < side_s) && (pz_r < height_s) &&
                    (layer_mat_r != 8'd0) && (ram_rdata == layer_mat_r);

  assign p_last = (py_r == hiy_r) && (px_r == hix_r) && (pz_r == hiz_r);

  assign dx      = x2_r - sx_r + ONE_C;
  assign dz      = z2_r - lvl_r + ONE_Z;
  assign n_cells = NW'(prod_r) * NW'(dz);

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_GRID_SIDE:      prdata = {27'd0, grid_side_r};
      REG_GRID_HEIGHT:    prdata = {27'd0, grid_height_r};
      REG_MERGE_MODE:     prdata = {31'd0, merge_mode_r};
      REG_LAYER_MATERIAL: prdata = {24'd0, layer_mat_r};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r   <= GRID_SIDE_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      merge_mode_r  <= MERGE_MODE_RST;
      layer_mat_r   <= LAYER_MATERIAL_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_GRID_SIDE:      grid_side_r   <= pwdata[4:0];
        REG_GRID_HEIGHT:    grid_height_r <= pwdata[4:0];
        REG_MERGE_MODE:     merge_mode_r  <= pwdata[0];
        REG_LAYER_MATERIAL: layer_mat_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // RAM write port: clearing pass, voxel writes and box clearing.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = 8'd0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == S_BCLR) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(pz_r, px_r, py_r);
    end else if (in_acc && in_command == CMD_WRITE && int'(in_pos_x) < MAX_SIDE &&
                 int'(in_pos_y) < MAX_SIDE && int'(in_pos_z) < MAX_HEIGHT) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(int'(in_pos_z) * (MAX_SIDE * MAX_SIDE) +
                      int'(in_pos_x) * MAX_SIDE + int'(in_pos_y));
      ram_wdata = in_cell_value;
    end
  end

  assign ram_raddr = cell_addr(pz_nxt, px_nxt, py_nxt);

  gvbm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search sequencer.
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    clr_nxt      = clr_r;
    lvl_nxt      = lvl_r;
    idx_nxt      = idx_r;
    ss_nxt       = ss_r;
    total_nxt    = total_r;
    rem_nxt      = rem_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    x2_nxt       = x2_r;
    y2_nxt       = y2_r;
    z2_nxt       = z2_r;
    fl_nxt       = fl_r;
    dir_nxt      = dir_r;
    lox_nxt      = lox_r;
    hix_nxt      = hix_r;
    loy_nxt      = loy_r;
    hiy_nxt      = hiy_r;
    loz_nxt      = loz_r;
    hiz_nxt      = hiz_r;
    pz_nxt       = pz_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    prod_nxt     = prod_r;
    best_nxt     = best_r;
    bx1_nxt      = bx1_r;
    bx2_nxt      = bx2_r;
    by1_nxt      = by1_r;
    by2_nxt      = by2_r;
    bz2_nxt      = bz2_r;
    res_kind_nxt = res_kind_r;
    res_x1_nxt   = res_x1_r;
    res_x2_nxt   = res_x2_r;
    res_y1_nxt   = res_y1_r;
    res_y2_nxt   = res_y2_r;
    res_z1_nxt   = res_z1_r;
    res_z2_nxt   = res_z2_r;

    case (state_r)
      // Zero the whole store after reset.
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_command))
            CMD_START: begin
              phase_nxt = PH_MERGE;
              lvl_nxt   = '0;
              idx_nxt   = '0;
            end
            CMD_FETCH: state_nxt = S_MUL1;
            default: ;
          endcase
        end
      end

      // Plane and grid sizes for the single scan.
      S_MUL1: begin
        ss_nxt    = SSW'(side_s) * SSW'(side_s);
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        total_nxt = IW'(ss_r) * IW'(height_s);
        case (phase_r)
          PH_MERGE:  state_nxt = S_LVL;
          PH_SINGLE: state_nxt = S_SCHK;
          default: begin
            res_kind_nxt = KIND_DONE;
            res_x1_nxt   = 4'd0;
            res_x2_nxt   = 4'd0;
            res_y1_nxt   = 4'd0;
            res_y2_nxt   = 4'd0;
            res_z1_nxt   = 4'd0;
            res_z2_nxt   = 4'd0;
            state_nxt    = S_EMIT;
          end
        endcase
      end

      // Start a search of the current level, or move to the single scan.
      S_LVL: begin
        if (lvl_r >= height_s) begin
          phase_nxt = PH_SINGLE;
          idx_nxt   = '0;
          state_nxt = S_SCHK;
        end else if (side_s == '0) begin
          lvl_nxt = lvl_r + ONE_Z;
        end else begin
          sx_nxt    = '0;
          sy_nxt    = '0;
          best_nxt  = '0;
          pz_nxt    = lvl_r;
          px_nxt    = '0;
          py_nxt    = '0;
          state_nxt = S_SEED;
        end
      end

      S_SEED: begin
        if (!cell_mat) begin
          state_nxt = S_ADV;
        end else begin
          py_nxt    = sy_r + ONE_C;
          state_nxt = S_NB1;
        end
      end

      // A seed needs at least one matching neighbor.
      S_NB1: begin
        if (cell_mat) begin
          state_nxt = S_GDIR;
        end else begin
          px_nxt    = sx_r + ONE_C;
          py_nxt    = sy_r;
          state_nxt = S_NB2;
        end
      end

      S_NB2: begin
        if (cell_mat) begin
          state_nxt = S_GDIR;
        end else if (merge_mode_r) begin
          pz_nxt    = lvl_r + ONE_Z;
          px_nxt    = sx_r;
          state_nxt = S_NB3;
        end else begin
          state_nxt = S_ADV;
        end
      end

      S_NB3: begin
        state_nxt = cell_mat ? S_GDIR : S_ADV;
      end

      // Next seed in x, y order.
      S_ADV: begin
        pz_nxt = lvl_r;
        if (sy_r + ONE_C < side_s) begin
          sy_nxt    = sy_r + ONE_C;
          px_nxt    = sx_r;
          py_nxt    = sy_r + ONE_C;
          state_nxt = S_SEED;
        end else if (sx_r + ONE_C < side_s) begin
          sx_nxt    = sx_r + ONE_C;
          sy_nxt    = '0;
          px_nxt    = sx_r + ONE_C;
          py_nxt    = '0;
          state_nxt = S_SEED;
        end else begin
          state_nxt = S_LEND;
        end
      end

      // Pick the next growth step, or finish the box.
      S_GDIR: begin
        if (fl_r == 3'b111) begin
          state_nxt = S_EV1;
        end else if (fl_r[dir_r]) begin
          dir_nxt = next_dir(dir_r);
        end else begin
          case (dir_r)
            DIR_X: begin
              if (x2_r + ONE_C < side_s) begin
                lox_nxt   = x2_r + ONE_C;
                hix_nxt   = x2_r + ONE_C;
                loy_nxt   = sy_r;
                hiy_nxt   = y2_r;
                loz_nxt   = lvl_r;
                hiz_nxt   = z2_r;
                state_nxt = S_SLAB;
              end else begin
                fl_nxt[DIR_X] = 1'b1;
                dir_nxt       = next_dir(dir_r);
              end
            end
            DIR_Y: begin
              if (y2_r + ONE_C < side_s) begin
                lox_nxt   = sx_r;
                hix_nxt   = x2_r;
                loy_nxt   = y2_r + ONE_C;
                hiy_nxt   = y2_r + ONE_C;
                loz_nxt   = lvl_r;
                hiz_nxt   = z2_r;
                state_nxt = S_SLAB;
              end else begin
                fl_nxt[DIR_Y] = 1'b1;
                dir_nxt       = next_dir(dir_r);
              end
            end
            default: begin
              if (z2_r + ONE_Z < height_s) begin
                lox_nxt   = sx_r;
                hix_nxt   = x2_r;
                loy_nxt   = sy_r;
                hiy_nxt   = y2_r;
                loz_nxt   = z2_r + ONE_Z;
                hiz_nxt   = z2_r + ONE_Z;
                state_nxt = S_SLAB;
              end else begin
                fl_nxt[DIR_Z] = 1'b1;
                dir_nxt       = next_dir(dir_r);
              end
            end
          endcase
          pz_nxt = loz_nxt;
          px_nxt = lox_nxt;
          py_nxt = loy_nxt;
        end
      end

      // Check the new slab cell by cell.
      S_SLAB: begin
        if (!cell_mat) begin
          fl_nxt[dir_r] = 1'b1;
          dir_nxt       = next_dir(dir_r);
          state_nxt     = S_GDIR;
        end else if (p_last) begin
          case (dir_r)
            DIR_X:   x2_nxt = x2_r + ONE_C;
            DIR_Y:   y2_nxt = y2_r + ONE_C;
            default: z2_nxt = z2_r + ONE_Z;
          endcase
          dir_nxt   = next_dir(dir_r);
          state_nxt = S_GDIR;
        end else if (py_r != hiy_r) begin
          py_nxt = py_r + ONE_C;
        end else if (px_r != hix_r) begin
          py_nxt = loy_r;
          px_nxt = px_r + ONE_C;
        end else begin
          py_nxt = loy_r;
          px_nxt = lox_r;
          pz_nxt = pz_r + ONE_Z;
        end
      end

      // Box volume: the x-y product is registered, then multiplied by the depth.
      S_EV1: begin
        prod_nxt  = PW'(dx) * PW'(y2_r - sy_r + ONE_C);
        state_nxt = S_EV2;
      end

      S_EV2: begin
        if (n_cells > NW'(1) && n_cells > best_r) begin
          best_nxt = n_cells;
          bx1_nxt  = sx_r;
          bx2_nxt  = x2_r;
          by1_nxt  = sy_r;
          by2_nxt  = y2_r;
          bz2_nxt  = z2_r;
        end
        state_nxt = S_ADV;
      end

      // Level done: clear the best box, or go up one level.
      S_LEND: begin
        if (best_r == '0) begin
          lvl_nxt   = lvl_r + ONE_Z;
          state_nxt = S_LVL;
        end else begin
          lox_nxt   = bx1_r;
          hix_nxt   = bx2_r;
          loy_nxt   = by1_r;
          hiy_nxt   = by2_r;
          loz_nxt   = lvl_r;
          hiz_nxt   = bz2_r;
          pz_nxt    = lvl_r;
          px_nxt    = bx1_r;
          py_nxt    = by1_r;
          state_nxt = S_BCLR;
        end
      end

      // Every cell of the box holds the material; zero them one a cycle.
      S_BCLR: begin
        if (p_last) begin
          res_kind_nxt = KIND_BOX;
          res_x1_nxt   = 4'(bx1_r);
          res_x2_nxt   = 4'(bx2_r);
          res_y1_nxt   = 4'(by1_r);
          res_y2_nxt   = 4'(by2_r);
          res_z1_nxt   = 4'(lvl_r);
          res_z2_nxt   = 4'(bz2_r);
          state_nxt    = S_EMIT;
        end else if (py_r != hiy_r) begin
          py_nxt = py_r + ONE_C;
        end else if (px_r != hix_r) begin
          py_nxt = loy_r;
          px_nxt = px_r + ONE_C;
        end else begin
          py_nxt = loy_r;
          px_nxt = lox_r;
          pz_nxt = pz_r + ONE_Z;
        end
      end

      // Single scan: split the linear index into z, x, y.
      S_SCHK: begin
        if (idx_r >= total_r) begin
          phase_nxt    = PH_DONE;
          res_kind_nxt = KIND_DONE;
          res_x1_nxt   = 4'd0;
          res_x2_nxt   = 4'd0;
          res_y1_nxt   = 4'd0;
          res_y2_nxt   = 4'd0;
          res_z1_nxt   = 4'd0;
          res_z2_nxt   = 4'd0;
          state_nxt    = S_EMIT;
        end else begin
          rem_nxt   = idx_r;
          pz_nxt    = '0;
          state_nxt = S_DIVZ;
        end
      end

      S_DIVZ: begin
        if (rem_r >= IW'(ss_r)) begin
          rem_nxt = rem_r - IW'(ss_r);
          pz_nxt  = pz_r + ONE_Z;
        end else begin
          px_nxt    = '0;
          state_nxt = S_DIVX;
        end
      end

      S_DIVX: begin
        if (rem_r >= IW'(side_s)) begin
          rem_nxt = rem_r - IW'(side_s);
          px_nxt  = px_r + ONE_C;
        end else begin
          py_nxt    = CW'(rem_r);
          state_nxt = S_SCAN;
        end
      end

      // Walk the grid in z, x, y order until a matching voxel.
      S_SCAN: begin
        idx_nxt = idx_r + IW'(1);
        if (cell_mat) begin
          res_kind_nxt = KIND_SINGLE;
          res_x1_nxt   = 4'(px_r);
          res_x2_nxt   = 4'(px_r);
          res_y1_nxt   = 4'(py_r);
          res_y2_nxt   = 4'(py_r);
          res_z1_nxt   = 4'(pz_r);
          res_z2_nxt   = 4'(pz_r);
          state_nxt    = S_EMIT;
        end else if (idx_r + IW'(1) >= total_r) begin
          phase_nxt    = PH_DONE;
          res_kind_nxt = KIND_DONE;
          res_x1_nxt   = 4'd0;
          res_x2_nxt   = 4'd0;
          res_y1_nxt   = 4'd0;
          res_y2_nxt   = 4'd0;
          res_z1_nxt   = 4'd0;
          res_z2_nxt   = 4'd0;
          state_nxt    = S_EMIT;
        end else if (py_r + ONE_C < side_s) begin
          py_nxt = py_r + ONE_C;
        end else if (px_r + ONE_C < side_s) begin
          py_nxt = '0;
          px_nxt = px_r + ONE_C;
        end else begin
          py_nxt = '0;
          px_nxt = '0;
          pz_nxt = pz_r + ONE_Z;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Growth starts from the seed alone.
    if ((state_r == S_NB1 || state_r == S_NB2 || state_r == S_NB3) && cell_mat) begin
      x2_nxt  = sx_r;
      y2_nxt  = sy_r;
      z2_nxt  = lvl_r;
      fl_nxt  = {!merge_mode_r, 2'b00};
      dir_nxt = DIR_X;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_MERGE;
      clr_r       <= '0;
      lvl_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_r       <= clr_nxt;
      lvl_r       <= lvl_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    ss_r       <= ss_nxt;
    total_r    <= total_nxt;
    rem_r      <= rem_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    z2_r       <= z2_nxt;
    fl_r       <= fl_nxt;
    dir_r      <= dir_nxt;
    lox_r      <= lox_nxt;
    hix_r      <= hix_nxt;
    loy_r      <= loy_nxt;
    hiy_r      <= hiy_nxt;
    loz_r      <= loz_nxt;
    hiz_r      <= hiz_nxt;
    pz_r       <= pz_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    prod_r     <= prod_nxt;
    best_r     <= best_nxt;
    bx1_r      <= bx1_nxt;
    bx2_r      <= bx2_nxt;
    by1_r      <= by1_nxt;
    by2_r      <= by2_nxt;
    bz2_r      <= bz2_nxt;
    res_kind_r <= res_kind_nxt;
    res_x1_r   <= res_x1_nxt;
    res_x2_r   <= res_x2_nxt;
    res_y1_r   <= res_y1_nxt;
    res_y2_r   <= res_y2_nxt;
    res_z1_r   <= res_z1_nxt;
    res_z2_r   <= res_z2_nxt;
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= res_kind_r;
      out_x1_r   <= res_x1_r;
      out_x2_r   <= res_x2_r;
      out_y1_r   <= res_y1_r;
      out_y2_r   <= res_y2_r;
      out_z1_r   <= res_z1_r;
      out_z2_r   <= res_z2_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item_kind = out_kind_r;
  assign out_x_low     = out_x1_r;
  assign out_x_high    = out_x2_r;
  assign out_y_low     = out_y1_r;
  assign out_y_high    = out_y2_r;
  assign out_z_low     = out_z1_r;
  assign out_z_high    = out_z2_r;

`ifndef SYNTHESIS
  // A fetch holds off further items until its result is produced.
  a_fetch_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_FETCH) |=> !in_ready)
    else $error("item accepted while a fetch is in progress");

  // A growing box never shrinks below its seed.
  a_grow_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GDIR || state_r == S_SLAB) |->
      (x2_r >= sx_r && y2_r >= sy_r && z2_r >= lvl_r))
    else $error("box bounds fell below the seed");

  // A recorded best box is well formed.
  a_best_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEND && best_r != '0) |->
      (bx1_r <= bx2_r && by1_r <= by2_r && bz2_r >= lvl_r))
    else $error("best box bounds out of order");

  // A result appears only at the end of a fetch.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule
